/* design/milling_cutting_force_defines.svh */
// Assertion macros for the milling cutting force design files.
`ifndef MILLING_CUTTING_FORCE_DEFINES_SVH
`define MILLING_CUTTING_FORCE_DEFINES_SVH

`ifndef SYNTH
// Checked at every rising edge outside of reset.
`define MCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define MCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MCF_ASSERT(lbl, prop, msg)
`define MCF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/mcf_pkg.sv */
// Shared types and constants of the milling cutting force block.
`timescale 1ns / 1ps
`default_nettype none

package mcf_pkg;

  localparam int unsigned CutCoeffW  = 16;
  localparam int unsigned EdgeCoeffW = 12;
  localparam int unsigned AngleW     = 16;
  localparam int unsigned ThickW     = 16;
  localparam int unsigned DepthW     = 14;
  localparam int unsigned ForceW     = 31;
  localparam int unsigned ForceXyW   = 32;
  localparam int unsigned SineW      = 16;
  localparam int unsigned SineMagW   = 15;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 96;

  // Aluminium preset.
  localparam logic [CutCoeffW-1:0]  KcTangReset  = 16'd796;
  localparam logic [CutCoeffW-1:0]  KcRadReset   = 16'd362;
  localparam logic [CutCoeffW-1:0]  KcAxReset    = 16'd235;
  localparam logic [EdgeCoeffW-1:0] KeTangReset  = 12'd18;
  localparam logic [EdgeCoeffW-1:0] KeRadReset   = 12'd9;
  localparam logic [EdgeCoeffW-1:0] KeAxReset    = 12'd6;
  localparam logic [AngleW-1:0]     EntryReset   = 16'd0;
  localparam logic [AngleW-1:0]     ExitReset    = 16'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KC_TANG = 3'd0,
    CFG_KC_RAD  = 3'd1,
    CFG_KC_AX   = 3'd2,
    CFG_KE_TANG = 3'd3,
    CFG_KE_RAD  = 3'd4,
    CFG_KE_AX   = 3'd5,
    CFG_ENTRY   = 3'd6,
    CFG_EXIT    = 3'd7
  } mcf_cfg_idx_e;

  typedef struct packed {
    logic [CutCoeffW-1:0]  kc_tang;
    logic [CutCoeffW-1:0]  kc_rad;
    logic [CutCoeffW-1:0]  kc_ax;
    logic [EdgeCoeffW-1:0] ke_tang;
    logic [EdgeCoeffW-1:0] ke_rad;
    logic [EdgeCoeffW-1:0] ke_ax;
  } mcf_coef_t;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } mcf_adv_t;

endpackage

`default_nettype wire

/* design/milling_cutting_force.sv */
// Top level of the milling cutting force block: configuration, pipeline control, outputs.
//
//   Channel  Dir  Beat contents
//   s_axis   in   chip_thickness, axial_depth, tool_angle
//   m_axis   out  force_x, force_y, force_z, engaged
//   cfg      in   register index and write data, no read-back
//
// One beat is accepted per clock unless every stage is full under an output stall; its
// result is offered once it has passed through the four register stages below.
// Four register stages: table read and coefficient products, edge term times depth,
// rotation products, sum and floor into the output register.
// Reset loads the aluminium preset and empties the pipeline.
// A full stage holds only while the next cannot accept, so bubbles close up in a stall.
`timescale 1ns / 1ps
`default_nettype none

module milling_cutting_force import mcf_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // chip_thickness[15:0], axial_depth[29:16], tool_angle[45:30], zero fill
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // force_x[31:0], force_y[63:32], force_z[94:64], engaged[95]
  output logic      [OutDataW-1:0] m_axis_tdata,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  `include "milling_cutting_force_defines.svh"

  localparam int unsigned TabW    = SINE_TABLE_BITS;
  localparam int unsigned AddrW   = SINE_TABLE_BITS - 1;
  localparam int unsigned Quarter = 1 << (SINE_TABLE_BITS - 2);

  // Configuration registers.
  mcf_coef_t         coef_q;
  logic [AngleW-1:0] entry_q, exit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.kc_tang <= KcTangReset;
      coef_q.kc_rad  <= KcRadReset;
      coef_q.kc_ax   <= KcAxReset;
      coef_q.ke_tang <= KeTangReset;
      coef_q.ke_rad  <= KeRadReset;
      coef_q.ke_ax   <= KeAxReset;
      entry_q        <= EntryReset;
      exit_q         <= ExitReset;
    end else if (cfg_we_i) begin
      unique case (mcf_cfg_idx_e'(cfg_idx_i))
        CFG_KC_TANG: coef_q.kc_tang <= cfg_wdata_i;
        CFG_KC_RAD:  coef_q.kc_rad  <= cfg_wdata_i;
        CFG_KC_AX:   coef_q.kc_ax   <= cfg_wdata_i;
        CFG_KE_TANG: coef_q.ke_tang <= cfg_wdata_i[EdgeCoeffW-1:0];
        CFG_KE_RAD:  coef_q.ke_rad  <= cfg_wdata_i[EdgeCoeffW-1:0];
        CFG_KE_AX:   coef_q.ke_ax   <= cfg_wdata_i[EdgeCoeffW-1:0];
        CFG_ENTRY:   entry_q        <= cfg_wdata_i;
        CFG_EXIT:    exit_q         <= cfg_wdata_i;
        default:     entry_q        <= entry_q;
      endcase
    end
  end

  // Input beat fields.
  logic [ThickW-1:0] thick;
  logic [DepthW-1:0] depth;
  logic [AngleW-1:0] angle;

  assign thick = s_axis_tdata[15:0];
  assign depth = s_axis_tdata[29:16];
  assign angle = s_axis_tdata[45:30];

  // Pipeline valid bits and per-stage ready.
  logic     v1_q, v2_q, v3_q, v4_q;
  logic     rdy1, rdy2, rdy3, rdy4;
  mcf_adv_t adv;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign adv  = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4_q;

  // Table addressing: fold the angle onto the first quarter turn.
  function automatic logic [AddrW-1:0] fold_addr(input logic [TabW-1:0] idx);
    logic [TabW-3:0] r;
    r = idx[TabW-3:0];
    return idx[TabW-2] ? (AddrW'(Quarter) - AddrW'(r)) : AddrW'(r);
  endfunction

  logic [TabW-1:0]     sin_idx, cos_idx;
  logic [AddrW-1:0]    sin_addr, cos_addr;
  logic [SineMagW-1:0] sin_mag, cos_mag;

  assign sin_idx  = angle[AngleW-1 -: TabW];
  assign cos_idx  = sin_idx + TabW'(Quarter);
  assign sin_addr = fold_addr(sin_idx);
  assign cos_addr = fold_addr(cos_idx);

  mcf_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .en_i    (adv.s1),
    .addr_a_i(sin_addr),
    .addr_b_i(cos_addr),
    .data_a_o(sin_mag),
    .data_b_o(cos_mag)
  );

  // Engagement window, which wraps past zero when entry lies above exit.
  logic engaged_d;

  always_comb begin
    if (entry_q <= exit_q) begin
      engaged_d = (angle >= entry_q) && (angle <= exit_q);
    end else begin
      engaged_d = (angle >= entry_q) || (angle <= exit_q);
    end
  end

  // Side-band flags and staged data travelling with the beat.
  logic                    zero1_q, zero2_q, zero3_q;
  logic                    eng1_q, eng2_q, eng3_q, eng4_q;
  logic                    sin_neg1_q, cos_neg1_q;
  logic signed [SineW-1:0] sin2_q, cos2_q;
  logic [ForceW-1:0]       fz3_q, fz4_q;
  logic [ForceW-1:0]       f_tang, f_rad, f_ax;

  always_ff @(posedge clk_i) begin
    if (adv.s1) begin
      zero1_q    <= (thick == '0) || (depth == '0);
      eng1_q     <= engaged_d;
      sin_neg1_q <= sin_idx[TabW-1];
      cos_neg1_q <= cos_idx[TabW-1];
    end
    if (adv.s2) begin
      zero2_q <= zero1_q;
      eng2_q  <= eng1_q;
      sin2_q  <= sin_neg1_q ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      cos2_q  <= cos_neg1_q ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    end
    if (adv.s3) begin
      zero3_q <= zero2_q;
      eng3_q  <= eng2_q;
      fz3_q   <= f_ax;
    end
    if (adv.s4) begin
      eng4_q <= eng3_q;
      fz4_q  <= zero3_q ? '0 : fz3_q;
    end
  end

  mcf_edge_force u_edge_force (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .coef_i  (coef_q),
    .thick_i (thick),
    .depth_i (depth),
    .f_tang_o(f_tang),
    .f_rad_o (f_rad),
    .f_ax_o  (f_ax)
  );

  logic signed [ForceXyW-1:0] force_x, force_y;

  mcf_rotate u_rotate (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .f_tang_i (f_tang),
    .f_rad_i  (f_rad),
    .sin_i    (sin2_q),
    .cos_i    (cos2_q),
    .zero_i   (zero3_q),
    .force_x_o(force_x),
    .force_y_o(force_y)
  );

  assign m_axis_tdata = {eng4_q, fz4_q, force_y, force_x};

  // A sample with no cut must leave the output stage with all forces zero.
  `MCF_ASSERT(a_zero_cut, (v3_q && rdy4 && zero3_q) |=> (force_x == '0 && force_y == '0 && fz4_q == '0), "zero cut gave a nonzero force")
  // A beat behind a stalled output stage must stay in place.
  `MCF_ASSERT(a_stall_holds, (v3_q && v4_q && !m_axis_tready) |=> v3_q, "beat dropped behind a stalled output")
  // The input is only held off when every stage is full.
  `MCF_ASSERT_ALWAYS(a_full_backpressure, !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q), "input stalled with a free stage")

endmodule

`default_nettype wire

/* design/mcf_sine_rom.sv */
// Quarter-wave sine table with two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mcf_sine_rom import mcf_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [SINE_TABLE_BITS-2:0] addr_a_i,
  input  wire logic [SINE_TABLE_BITS-2:0] addr_b_i,
  output logic      [SineMagW-1:0]        data_a_o,
  output logic      [SineMagW-1:0]        data_b_o
);

  localparam int unsigned Depth     = (1 << (SINE_TABLE_BITS - 2)) + 1;
  localparam real         TwoPi     = 6.28318530717958647;
  localparam real         AngleStep = TwoPi / real'(1 << SINE_TABLE_BITS);

  typedef logic [SineMagW-1:0] rom_t [Depth];

  // Entry j holds round(32767 * sin(j steps)) for the first quarter turn, both ends included.
  function automatic rom_t rom_init();
    rom_t tbl;
    real  v;
    for (int j = 0; j < Depth; j++) begin
      v      = 32767.0 * $sin(real'(j) * AngleStep);
      tbl[j] = SineMagW'($rtoi(v + 0.5));
    end
    return tbl;
  endfunction

  localparam rom_t SineRom = rom_init();

  logic [SineMagW-1:0] data_a_q;
  logic [SineMagW-1:0] data_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= SineRom[addr_a_i];
      data_b_q <= SineRom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

`default_nettype wire

/* design/mcf_edge_force.sv */
// Linear edge-force stages: coefficient times thickness, then plus edge term, the sum times depth.
`timescale 1ns / 1ps
`default_nettype none

module mcf_edge_force import mcf_pkg::*; (
  input  wire logic              clk_i,
  input  wire mcf_adv_t          adv_i,
  input  wire mcf_coef_t         coef_i,
  input  wire logic [ThickW-1:0] thick_i,
  input  wire logic [DepthW-1:0] depth_i,
  output logic      [ForceW-1:0] f_tang_o,
  output logic      [ForceW-1:0] f_rad_o,
  output logic      [ForceW-1:0] f_ax_o
);

  localparam int unsigned ProdW = CutCoeffW + ThickW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned WideW = SumW + DepthW;

  logic [ProdW-1:0]  p_tang_q, p_rad_q, p_ax_q;
  logic [ProdW-1:0]  p_tang_d, p_rad_d, p_ax_d;
  logic [DepthW-1:0] depth_q;
  logic [ForceW-1:0] f_tang_q, f_rad_q, f_ax_q;
  logic [ForceW-1:0] f_tang_d, f_rad_d, f_ax_d;

  assign p_tang_d = ProdW'(coef_i.kc_tang) * ProdW'(thick_i);
  assign p_rad_d  = ProdW'(coef_i.kc_rad)  * ProdW'(thick_i);
  assign p_ax_d   = ProdW'(coef_i.kc_ax)   * ProdW'(thick_i);

  // (p + ke * 2^16) * depth, then drop the 16 fraction bits of the thickness.
  function automatic logic [ForceW-1:0] scale_force(input logic [ProdW-1:0]      p,
                                                     input logic [EdgeCoeffW-1:0] ke,
                                                     input logic [DepthW-1:0]     d);
    logic [SumW-1:0]  sum;
    logic [WideW-1:0] wide;
    sum  = SumW'(p) + SumW'({ke, 16'h0000});
    wide = WideW'(sum) * WideW'(d);
    return wide[WideW-1 -: ForceW];
  endfunction

  assign f_tang_d = scale_force(p_tang_q, coef_i.ke_tang, depth_q);
  assign f_rad_d  = scale_force(p_rad_q,  coef_i.ke_rad,  depth_q);
  assign f_ax_d   = scale_force(p_ax_q,   coef_i.ke_ax,   depth_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      p_tang_q <= p_tang_d;
      p_rad_q  <= p_rad_d;
      p_ax_q   <= p_ax_d;
      depth_q  <= depth_i;
    end
    if (adv_i.s2) begin
      f_tang_q <= f_tang_d;
      f_rad_q  <= f_rad_d;
      f_ax_q   <= f_ax_d;
    end
  end

  assign f_tang_o = f_tang_q;
  assign f_rad_o  = f_rad_q;
  assign f_ax_o   = f_ax_q;

endmodule

`default_nettype wire

/* design/mcf_rotate.sv */
// Rotation of tangential and radial force into the x/y frame, floored back to Q.8.
`timescale 1ns / 1ps
`default_nettype none

module mcf_rotate import mcf_pkg::*; (
  input  wire logic                       clk_i,
  input  wire mcf_adv_t                   adv_i,
  input  wire logic        [ForceW-1:0]   f_tang_i,
  input  wire logic        [ForceW-1:0]   f_rad_i,
  input  wire logic signed [SineW-1:0]    sin_i,
  input  wire logic signed [SineW-1:0]    cos_i,
  input  wire logic                       zero_i,
  output logic signed      [ForceXyW-1:0] force_x_o,
  output logic signed      [ForceXyW-1:0] force_y_o
);

  localparam int unsigned MulW = ForceXyW + SineW;

  logic signed [ForceXyW-1:0] ft_s, fr_s;
  logic signed [MulW-1:0]     tc_q, rs_q, ts_q, rc_q;
  logic signed [MulW-1:0]     sum_x, sum_y;
  logic signed [ForceXyW-1:0] force_x_q, force_y_q;
  logic signed [ForceXyW-1:0] force_x_d, force_y_d;

  assign ft_s = $signed({1'b0, f_tang_i});
  assign fr_s = $signed({1'b0, f_rad_i});

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      tc_q <= MulW'(ft_s) * MulW'(cos_i);
      rs_q <= MulW'(fr_s) * MulW'(sin_i);
      ts_q <= MulW'(ft_s) * MulW'(sin_i);
      rc_q <= MulW'(fr_s) * MulW'(cos_i);
    end
  end

  assign sum_x = rs_q - tc_q;
  assign sum_y = ts_q + rc_q;

  // Dropping the low 15 bits of a two's complement value floors it.
  assign force_x_d = zero_i ? '0 : sum_x[ForceXyW+14:15];
  assign force_y_d = zero_i ? '0 : sum_y[ForceXyW+14:15];

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      force_x_q <= force_x_d;
      force_y_q <= force_y_d;
    end
  end

  assign force_x_o = force_x_q;
  assign force_y_o = force_y_q;

endmodule

`default_nettype wire
